@@ rtl/top_k_outlier_rejected_mean_unit_macros.svh @@
// Assertion macros for the trimmed-mean unit.
// Used by the top level; no other dependencies.
`ifndef TOP_K_OUTLIER_REJECTED_MEAN_UNIT_MACROS_SVH
`define TOP_K_OUTLIER_REJECTED_MEAN_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TKM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define TKM_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("never failed");
`else
`define TKM_ASSERT(lbl, clk, rstn, prop)
`define TKM_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ rtl/tkm_pkg.sv @@
// Package for the trimmed-mean unit: widths, register indexes, payload types.
// No dependencies.
package tkm_pkg;
  localparam int unsigned DefHistoryDepth = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned RankW = 34;
  localparam int unsigned SumW = 64;
  localparam int unsigned CntW = 32;
  localparam int unsigned KcW = 5;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 34;
  localparam int unsigned AccW = 68;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeptCount = 1'b0,
    RegKnownMin  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ValW-1:0] moment_r;
    logic [ValW-1:0] moment_g;
    logic [ValW-1:0] moment_b;
    logic [ValW-1:0] sample_cost;
    logic            batch_end;
  } in_item_t;

  typedef struct packed {
    logic             has_lower_bound;
    logic [RankW-1:0] bound_sum;
    logic [ValW-1:0]  bound_cost;
    logic             mean_valid;
    logic [ValW-1:0]  mean_r;
    logic [ValW-1:0]  mean_g;
    logic [ValW-1:0]  mean_b;
    logic [ValW-1:0]  mean_cost;
  } out_item_t;

  typedef struct packed {
    logic [ValW-1:0] r;
    logic [ValW-1:0] g;
    logic [ValW-1:0] b;
    logic [ValW-1:0] c;
  } entry_t;

  typedef struct packed {
    logic             ins;
    logic [RankW-1:0] rank;
    entry_t           e;
  } cell_ctl_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;
endpackage

@@ rtl/tkm_stream_if.sv @@
// Valid/ready channel interface carrying a typed payload.
// The payload type is a parameter; no dependencies.
interface tkm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/tkm_cell.sv @@
// One slot of the sorted outlier row; takes the insert broadcast and its
// upper neighbour. Depends on tkm_pkg.
module tkm_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  logic                    en_i,
  input  logic                    ins_i,
  input  logic [tkm_pkg::RankW-1:0] rank_i,
  input  tkm_pkg::entry_t         new_i,
  input  logic                    up_valid_i,
  input  logic                    up_ge_i,
  input  tkm_pkg::entry_t         up_i,
  output logic                    valid_o,
  output logic                    ge_o,
  output tkm_pkg::entry_t         entry_o,
  output logic [tkm_pkg::RankW-1:0] rank_o
);
  logic valid_q, valid_d;
  tkm_pkg::entry_t entry_q, entry_d;
  logic [tkm_pkg::RankW-1:0] rank_q, rank_d;
  logic ge;

  assign ge = !valid_q || (rank_i >= rank_q);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    rank_d  = rank_q;
    if (clr_i) begin
      valid_d = 1'b0;
    end else if (en_i && ins_i && ge) begin
      if (up_valid_i && up_ge_i) begin
        entry_d = up_i;
        rank_d  = {2'b00, up_i.r} + {2'b00, up_i.g} + {2'b00, up_i.b};
        valid_d = 1'b1;
      end else if (up_valid_i) begin
        entry_d = new_i;
        rank_d  = rank_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rank_q  <= rank_d;
  end

  assign valid_o = valid_q;
  assign ge_o    = ge;
  assign entry_o = entry_q;
  assign rank_o  = rank_q;
endmodule

@@ rtl/tkm_divider.sv @@
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per
// cycle, saturating to 32 bits. Depends on tkm_pkg.
module tkm_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tkm_pkg::SumW-1:0]   num_i,
  input  logic [tkm_pkg::CntW-1:0]   den_i,
  output logic                       done_o,
  output logic [tkm_pkg::ValW-1:0]   quo_o
);
  localparam int unsigned StepW = $clog2(tkm_pkg::SumW + 1);
  logic [tkm_pkg::SumW-1:0] num_q, num_d;
  logic [tkm_pkg::CntW:0]   rem_q, rem_d;
  logic [tkm_pkg::CntW-1:0] den_q, den_d;
  logic [StepW-1:0]         cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic [tkm_pkg::CntW+1:0] trial;
  logic [tkm_pkg::CntW+1:0] shifted;

  always_comb begin
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q, num_q[tkm_pkg::SumW-1]};
    trial   = shifted - {2'b00, den_q};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = StepW'(tkm_pkg::SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[tkm_pkg::CntW+1]) begin
        rem_d = trial[tkm_pkg::CntW:0];
        num_d = {num_q[tkm_pkg::SumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[tkm_pkg::CntW:0];
        num_d = {num_q[tkm_pkg::SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = !busy_q;
  assign quo_o  = (|num_q[tkm_pkg::SumW-1:tkm_pkg::ValW]) ? '1 : num_q[tkm_pkg::ValW-1:0];
endmodule

@@ rtl/top_k_outlier_rejected_mean_unit.sv @@
// Trimmed-mean unit: running sums, a systolic row of sorted outlier cells and
// a shared serial divider. A sample's result is registered in StBnd and offered
// in StOut; a batch end instead takes a pass over the row, four divisions and a
// clear before StOut (the divisions are skipped when no samples remain). A new
// sample is taken only in StIdle, after the last result has been accepted.
// Reset clears sums, count, fill, registers and the row's valid bits.
`include "top_k_outlier_rejected_mean_unit_macros.svh"
module top_k_outlier_rejected_mean_unit #(
  parameter int unsigned HISTORY_DEPTH = tkm_pkg::DefHistoryDepth
) (
  input logic clk_i,
  input logic rst_ni,
  tkm_stream_if.sink   in_s,
  tkm_stream_if.source out_s,
  tkm_stream_if.sink   cfg_s
);
  localparam int unsigned IdxW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StOut   = 7'b0000010,
    StSum   = 7'b0000100,
    StDivSt = 7'b0001000,
    StDivWt = 7'b0010000,
    StDone  = 7'b0100000,
    StBnd   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  tkm_pkg::in_item_t  in_it;
  tkm_pkg::cfg_item_t cfg_it;
  tkm_pkg::out_item_t res_q, res_d;
  logic [tkm_pkg::KcW-1:0]   kc_q;
  logic [tkm_pkg::RankW-1:0] kmin_q;
  logic [tkm_pkg::SumW-1:0]  sum_q [4];
  logic [tkm_pkg::CntW-1:0]  tot_q;
  logic [FillW-1:0]          lim;
  logic                      in_fire, cfg_fire, clr;
  logic [tkm_pkg::RankW-1:0] rank;
  logic                      ins;
  logic [HISTORY_DEPTH-1:0]  cv, cge;
  tkm_pkg::entry_t           ce [HISTORY_DEPTH];
  logic [tkm_pkg::RankW-1:0] cr [HISTORY_DEPTH];
  logic [tkm_pkg::AccW-1:0]  acc_q [4];
  logic [IdxW-1:0]           sidx_q;
  logic [FillW-1:0]          fill;
  logic [1:0]                ch_q;
  logic                      dstart;
  logic                      ddone;
  logic [tkm_pkg::ValW-1:0]  dquo;
  logic [tkm_pkg::SumW-1:0]  dnum;
  logic [tkm_pkg::CntW-1:0]  rem;
  logic [tkm_pkg::ValW-1:0]  ent [4];

  assign in_it  = in_s.payload;
  assign cfg_it = cfg_s.payload;
  assign lim = (tkm_pkg::CntW'(kc_q) > HISTORY_DEPTH) ? FillW'(HISTORY_DEPTH) : FillW'(kc_q);
  assign in_s.ready  = (state_q == StIdle);
  assign cfg_s.ready = (state_q == StIdle);
  assign in_fire  = in_s.valid && in_s.ready;
  assign cfg_fire = cfg_s.valid && cfg_s.ready;
  assign clr = (cfg_fire && cfg_it.idx == tkm_pkg::RegKeptCount) || (state_q == StDone);
  assign rank = {2'b00, in_it.moment_r} + {2'b00, in_it.moment_g} + {2'b00, in_it.moment_b};
  assign ins = in_fire && (rank > kmin_q);

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic ena;
    assign ena = (FillW'(i) < lim);
    if (i == 0) begin : g_first
      tkm_cell u_cell (
        .clk_i, .rst_ni, .clr_i(clr), .en_i(ena), .ins_i(ins), .rank_i(rank),
        .new_i({in_it.moment_r, in_it.moment_g, in_it.moment_b, in_it.sample_cost}),
        .up_valid_i(1'b1), .up_ge_i(1'b0), .up_i(ce[0]),
        .valid_o(cv[i]), .ge_o(cge[i]), .entry_o(ce[i]), .rank_o(cr[i])
      );
    end else begin : g_rest
      tkm_cell u_cell (
        .clk_i, .rst_ni, .clr_i(clr), .en_i(ena), .ins_i(ins), .rank_i(rank),
        .new_i({in_it.moment_r, in_it.moment_g, in_it.moment_b, in_it.sample_cost}),
        .up_valid_i(cv[i-1]), .up_ge_i(cge[i-1]), .up_i(ce[i-1]),
        .valid_o(cv[i]), .ge_o(cge[i]), .entry_o(ce[i]), .rank_o(cr[i])
      );
    end
  end

  always_comb begin
    fill = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      fill = fill + FillW'(cv[i]);
    end
  end

  assign rem = (tot_q > tkm_pkg::CntW'(fill)) ? tot_q - tkm_pkg::CntW'(fill) : '0;
  assign ent[0] = ce[sidx_q].r;
  assign ent[1] = ce[sidx_q].g;
  assign ent[2] = ce[sidx_q].b;
  assign ent[3] = ce[sidx_q].c;
  assign dnum = (acc_q[ch_q][tkm_pkg::AccW-1:tkm_pkg::SumW] != '0) ? '0 :
                ((sum_q[ch_q] > acc_q[ch_q][tkm_pkg::SumW-1:0]) ?
                 sum_q[ch_q] - acc_q[ch_q][tkm_pkg::SumW-1:0] : '0);
  assign dstart = (state_q == StDivSt);

  tkm_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(rem),
    .done_o(ddone), .quo_o(dquo)
  );

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      StIdle: if (in_fire) begin
        state_d = in_it.batch_end ? StSum : StBnd;
      end
      StBnd: state_d = StOut;
      StOut: if (out_s.ready) begin
        state_d = StIdle;
      end
      StSum: if (FillW'(sidx_q) + 1'b1 >= FillW'(HISTORY_DEPTH)) begin
        state_d = (rem != '0) ? StDivSt : StDone;
        res_d.mean_valid = (rem != '0);
      end
      StDivSt: state_d = StDivWt;
      StDivWt: if (ddone) begin
        unique case (ch_q)
          2'd0: res_d.mean_r = dquo;
          2'd1: res_d.mean_g = dquo;
          2'd2: res_d.mean_b = dquo;
          default: res_d.mean_cost = dquo;
        endcase
        state_d = (ch_q == 2'd3) ? StDone : StDivSt;
      end
      StDone: state_d = StOut;
      default: state_d = StIdle;
    endcase
    if (state_q == StIdle) begin
      res_d = '0;
    end
    if (state_q == StBnd || (state_q == StSum && state_d != StSum)) begin
      res_d.has_lower_bound = (lim != '0) && (fill >= lim);
      res_d.bound_sum  = res_d.has_lower_bound ? cr[IdxW'(fill - 1'b1)] : '0;
      res_d.bound_cost = res_d.has_lower_bound ? ce[IdxW'(fill - 1'b1)].c : '0;
      res_d.mean_valid = (state_q == StSum) && (rem != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kc_q    <= '0;
      kmin_q  <= '0;
      tot_q   <= '0;
      sidx_q  <= '0;
      ch_q    <= '0;
      for (int k = 0; k < 4; k++) begin
        sum_q[k] <= '0;
        acc_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        unique case (cfg_it.idx)
          tkm_pkg::RegKeptCount: kc_q <= cfg_it.data[tkm_pkg::KcW-1:0];
          default: kmin_q <= cfg_it.data;
        endcase
      end
      if (clr) begin
        tot_q <= '0;
        for (int k = 0; k < 4; k++) begin
          sum_q[k] <= '0;
        end
      end else if (in_fire) begin
        if (tot_q != '1) begin
          tot_q <= tot_q + 1'b1;
        end
        sum_q[0] <= (sum_q[0] + 64'(in_it.moment_r) < sum_q[0]) ? '1 :
                    sum_q[0] + 64'(in_it.moment_r);
        sum_q[1] <= (sum_q[1] + 64'(in_it.moment_g) < sum_q[1]) ? '1 :
                    sum_q[1] + 64'(in_it.moment_g);
        sum_q[2] <= (sum_q[2] + 64'(in_it.moment_b) < sum_q[2]) ? '1 :
                    sum_q[2] + 64'(in_it.moment_b);
        sum_q[3] <= (sum_q[3] + 64'(in_it.sample_cost) < sum_q[3]) ? '1 :
                    sum_q[3] + 64'(in_it.sample_cost);
      end
      if (state_q == StIdle) begin
        sidx_q <= '0;
        ch_q   <= '0;
        for (int k = 0; k < 4; k++) begin
          acc_q[k] <= '0;
        end
      end else if (state_q == StSum) begin
        if (cv[sidx_q]) begin
          for (int k = 0; k < 4; k++) begin
            acc_q[k] <= acc_q[k] + tkm_pkg::AccW'(ent[k]);
          end
        end
        if (FillW'(sidx_q) + 1'b1 < FillW'(HISTORY_DEPTH)) begin
          sidx_q <= sidx_q + 1'b1;
        end
      end else if (state_q == StDivWt && ddone) begin
        ch_q <= ch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_s.valid   = (state_q == StOut);
  assign out_s.payload = res_q;

  `TKM_ASSERT(a_out_hold, clk_i, rst_ni, out_s.valid && !out_s.ready |=> out_s.valid)
  `TKM_ASSERT_NEVER(a_fill_lim, clk_i, rst_ni, fill > lim && state_q == StIdle && !$past(clr))
  `TKM_ASSERT_NEVER(a_no_in_busy, clk_i, rst_ni, in_fire && out_s.valid)
endmodule

@@ bench/tb_top.sv @@
// Testbench for the trimmed-mean unit: random and directed samples, batch ends
// and register writes, checked against an in-bench predictor of the outlier list and means.
// Depends on tkm_pkg, tkm_stream_if and top_k_outlier_rejected_mean_unit.
`timescale 1ns / 100ps
module tb_top;
  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 2000000;

  logic clk_i;
  logic rst_ni;

  tkm_stream_if #(.payload_t(tkm_pkg::in_item_t))  in_if ();
  tkm_stream_if #(.payload_t(tkm_pkg::out_item_t)) out_if ();
  tkm_stream_if #(.payload_t(tkm_pkg::cfg_item_t)) cfg_if ();

  top_k_outlier_rejected_mean_unit #(.HISTORY_DEPTH(Depth)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_if.sink),
    .out_s  (out_if.source),
    .cfg_s  (cfg_if.sink)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // predictor state
  tkm_pkg::entry_t top_list [Depth];
  int unsigned list_fill;
  logic [63:0] acc_r, acc_g, acc_b, acc_c;
  logic [31:0] n_samples;
  logic [4:0]  keep_cfg;
  logic [33:0] floor_cfg;

  tkm_pkg::in_item_t  sample_q [$];
  tkm_pkg::out_item_t result_q [$];
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  int unsigned n_taken = 0;
  int unsigned n_seen = 0;
  int unsigned drv_gap = 0;
  int unsigned mon_stall = 0;

  function automatic logic [33:0] rank_of(tkm_pkg::entry_t e);
    return {2'b0, e.r} + {2'b0, e.g} + {2'b0, e.b};
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {33'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] div_sat(logic [63:0] acc, logic [63:0] sub,
                                          logic [31:0] den);
    logic [63:0] num;
    logic [63:0] q;
    num = (acc > sub) ? acc - sub : 64'd0;
    q = num / {32'b0, den};
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic void clear_batch();
    list_fill = 0;
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
    acc_c = '0;
    n_samples = '0;
  endfunction

  function automatic tkm_pkg::out_item_t predict_trimmed(tkm_pkg::in_item_t s);
    tkm_pkg::out_item_t o;
    tkm_pkg::entry_t    e;
    logic [33:0] rk;
    int unsigned lim, pos;
    logic [63:0] tr, tg, tb, tc;
    logic [31:0] left;
    e = '{r: s.moment_r, g: s.moment_g, b: s.moment_b, c: s.sample_cost};
    rk = rank_of(e);
    lim = (keep_cfg > Depth) ? Depth : keep_cfg;
    o = '0;
    if (n_samples != 32'hFFFF_FFFF) n_samples++;
    acc_r = add_sat(acc_r, s.moment_r);
    acc_g = add_sat(acc_g, s.moment_g);
    acc_b = add_sat(acc_b, s.moment_b);
    acc_c = add_sat(acc_c, s.sample_cost);
    if (list_fill > lim) list_fill = lim;
    if (rk > floor_cfg) begin
      pos = list_fill;
      while (pos > 0 && rk >= rank_of(top_list[pos-1])) begin
        if (pos < lim) top_list[pos] = top_list[pos-1];
        pos--;
      end
      if (pos < lim) begin
        top_list[pos] = e;
        if (list_fill < lim) list_fill++;
      end
    end
    if (lim > 0 && list_fill >= lim) begin
      o.has_lower_bound = 1'b1;
      o.bound_sum = rank_of(top_list[list_fill-1]);
      o.bound_cost = top_list[list_fill-1].c;
    end
    if (s.batch_end) begin
      tr = '0;
      tg = '0;
      tb = '0;
      tc = '0;
      for (int i = 0; i < list_fill; i++) begin
        tr += top_list[i].r;
        tg += top_list[i].g;
        tb += top_list[i].b;
        tc += top_list[i].c;
      end
      left = (n_samples > list_fill) ? n_samples - list_fill : 32'd0;
      if (left != 0) begin
        o.mean_valid = 1'b1;
        o.mean_r = div_sat(acc_r, tr, left);
        o.mean_g = div_sat(acc_g, tg, left);
        o.mean_b = div_sat(acc_b, tb, left);
        o.mean_cost = div_sat(acc_c, tc, left);
      end
      clear_batch();
    end
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic tkm_pkg::in_item_t rand_sample(int unsigned end_pct);
    tkm_pkg::in_item_t s;
    s.moment_r = rand_val();
    s.moment_g = rand_val();
    s.moment_b = rand_val();
    s.sample_cost = rand_val();
    s.batch_end = ($urandom_range(0, 99) < end_pct);
    return s;
  endfunction

  // driver: present at falling edge, advance once the transfer has been seen
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || n_seen != n_taken) begin
        if (n_seen != n_taken) begin
          n_seen = n_taken;
          drv_gap = pick_gap();
        end
        if (drv_gap > 0) begin
          drv_gap--;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_if.payload <= sample_q.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        mon_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // monitor: record input transfers and check results at rising edge
  always @(posedge clk_i) begin
    tkm_pkg::out_item_t want, got;
    n_cycles++;
    if (in_if.valid && in_if.ready && rst_ni) begin
      result_q.push_back(predict_trimmed(in_if.payload));
      n_taken++;
    end
    if (out_if.valid && out_if.ready && rst_ni) begin
      got = out_if.payload;
      if (result_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch lb %b/%b bs %h/%h bc %h/%h", want.has_lower_bound,
                     got.has_lower_bound, want.bound_sum, got.bound_sum,
                     want.bound_cost, got.bound_cost);
            $display("  mv %b/%b r %h/%h g %h/%h b %h/%h c %h/%h", want.mean_valid,
                     got.mean_valid, want.mean_r, got.mean_r, want.mean_g,
                     got.mean_g, want.mean_b, got.mean_b, want.mean_cost,
                     got.mean_cost);
          end
        end
      end
    end
    if (n_cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic wait_idle();
    while (sample_q.size() > 0 || in_if.valid || result_q.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(tkm_pkg::cfg_reg_e idx, logic [33:0] val);
    @(negedge clk_i);
    cfg_if.payload <= '{idx: idx, data: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    if (idx == tkm_pkg::RegKeptCount) begin
      keep_cfg = val[4:0];
      clear_batch();
    end else begin
      floor_cfg = val;
    end
  endtask

  task automatic load_batch(int unsigned n);
    tkm_pkg::in_item_t s;
    for (int i = 0; i < n; i++) begin
      s = rand_sample(0);
      s.batch_end = (i == n - 1);
      sample_q.push_back(s);
    end
  endtask

  initial begin
    logic [4:0]  keeps [6];
    logic [33:0] floors [4];
    tkm_pkg::in_item_t s;
    keeps = '{5'd0, 5'd1, 5'd3, 5'd16, 5'd31, 5'd7};
    floors = '{34'd0, 34'h2_FFFF_FFFD, 34'h0_8000_0000, 34'h1_0000_0000};
    keep_cfg = '0;
    floor_cfg = '0;
    clear_batch();
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, ties, threshold, saturation, zero divisor
    write_reg(tkm_pkg::RegKeptCount, 34'd2);
    write_reg(tkm_pkg::RegKnownMin, 34'd5);
    s = '0;
    s.batch_end = 1'b1;
    sample_q.push_back(s);
    s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0};
    repeat (3) sample_q.push_back(s);
    s = '{32'd2, 32'd2, 32'd1, 32'd9, 1'b0};
    sample_q.push_back(s);
    s = '{32'd2, 32'd2, 32'd2, 32'd7, 1'b0};
    repeat (2) sample_q.push_back(s);
    s = '{32'd1, 32'd0, 32'd0, 32'd1, 1'b1};
    sample_q.push_back(s);
    s = '{32'd9, 32'd0, 32'd0, 32'd3, 1'b1};
    sample_q.push_back(s);
    s = '{32'hAAAA_5555, 32'h5555_AAAA, 32'h0F0F_F0F0, 32'hF0F0_0F0F, 1'b0};
    sample_q.push_back(s);
    s = '{32'h5555_AAAA, 32'hAAAA_5555, 32'hF0F0_0F0F, 32'h0F0F_F0F0, 1'b1};
    sample_q.push_back(s);
    wait_idle();
    write_reg(tkm_pkg::RegKeptCount, 34'd31);
    write_reg(tkm_pkg::RegKnownMin, 34'h3_FFFF_FFFF);
    load_batch(5);
    wait_idle();
    write_reg(tkm_pkg::RegKnownMin, 34'd0);
    load_batch(20);
    wait_idle();

    // random phases across settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(tkm_pkg::RegKnownMin, (ph % 3 == 0) ? floors[$urandom_range(0, 3)] :
                {2'($urandom_range(0, 3)), 32'($urandom)});
      write_reg(tkm_pkg::RegKeptCount, 34'(keeps[ph % 6]));
      for (int i = 0; i < 90; i++) sample_q.push_back(rand_sample(4));
      if (ph == 5) begin
        while (sample_q.size() > 0 || in_if.valid || result_q.size() > 0)
          @(posedge clk_i);
      end
      wait_idle();
    end

    // a long batch with the kept count at 16
    write_reg(tkm_pkg::RegKeptCount, 34'd16);
    load_batch(60);
    wait_idle();

    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/tkm_pkg.sv
rtl/tkm_stream_if.sv
rtl/tkm_cell.sv
rtl/tkm_divider.sv
rtl/top_k_outlier_rejected_mean_unit.sv
bench/tb_top.sv
